@@ design/dual_set_dma_channel_engine_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef DUAL_SET_DMA_CHANNEL_ENGINE_UNIT_ASSERT_SVH
`define DUAL_SET_DMA_CHANNEL_ENGINE_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define DSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define DSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/dsdma_pkg.sv @@
// ----------------------------------------------------------------------------
// dsdma_pkg
// Types, constants and register codes of the dual-set DMA channel engine.
// ----------------------------------------------------------------------------
package dsdma_pkg;

    localparam int DEF_CHANNELS = 7;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_XFER  = 2'd2;

    localparam logic [4:0] CS_IF   = 5'h01;
    localparam logic [4:0] CS_DIR  = 5'h02;
    localparam logic [4:0] CS_TERM = 5'h04;
    localparam logic [4:0] CS_EN   = 5'h08;
    localparam logic [4:0] CS_IE   = 5'h10;

    localparam logic [31:0] ADDR_LIMIT = 32'h4000_0000;
    localparam logic [12:0] CTRL_BASE  = 13'h0C00;
    localparam logic [12:0] SET_BASE   = 13'h1000;
    localparam logic [12:0] ISR_BASE   = 13'h0804;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CTRL_RD,
        OP_SET_RD,
        OP_ISR_RD,
        OP_CTRL_WR,
        OP_SET_WR,
        OP_XFER
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  chan;
        logic        set_sel;
        logic [3:0]  sub;
        logic [7:0]  wdata;
        logic        to_mem;
        logic [15:0] length;
    } t_cmd;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

@@ design/dsdma_front.sv @@
// ----------------------------------------------------------------------------
// dsdma_front
// Decodes a command into an operation and pushes it into a one-entry queue.
// ----------------------------------------------------------------------------
module dsdma_front
    import dsdma_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_kind,
    input  logic [12:0] i_reg_offset,
    input  logic [7:0]  i_write_data,
    input  logic [2:0]  i_channel,
    input  logic        i_dev_to_mem,
    input  logic [15:0] i_length,
    input  logic        i_pop,
    output logic        o_busy,
    output logic        o_valid,
    output t_cmd        o_cmd
);

    localparam logic [13:0] CTRL_END = 14'(CTRL_BASE) + 14'(16 * CHANNELS);
    localparam logic [13:0] SET_END  = 14'(SET_BASE) + 14'(32 * CHANNELS);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic [12:0] ctrl_rel;
    logic [12:0] set_rel;

    assign ctrl_rel = i_reg_offset - CTRL_BASE;
    assign set_rel  = i_reg_offset - SET_BASE;

    always_comb begin
        n_cmd        = '0;
        n_cmd.op     = OP_NONE;
        n_cmd.wdata  = i_write_data;
        n_cmd.to_mem = i_dev_to_mem;
        n_cmd.length = i_length;
        n_cmd.sub    = i_reg_offset[3:0];
        if (i_kind == KIND_XFER) begin
            n_cmd.chan = {1'b0, i_channel};
            if (32'(i_channel) < 32'(CHANNELS)) begin
                n_cmd.op = OP_XFER;
            end
        end else if (i_kind == KIND_READ || i_kind == KIND_WRITE) begin
            if ({1'b0, i_reg_offset} >= 14'(CTRL_BASE) && {1'b0, i_reg_offset} < CTRL_END)
            begin
                n_cmd.chan = ctrl_rel[7:4];
                n_cmd.op   = (i_kind == KIND_READ) ? OP_CTRL_RD : OP_CTRL_WR;
            end else if ({1'b0, i_reg_offset} >= 14'(SET_BASE) &&
                         {1'b0, i_reg_offset} < SET_END) begin
                n_cmd.chan    = set_rel[8:5];
                n_cmd.set_sel = set_rel[4];
                n_cmd.op      = (i_kind == KIND_READ) ? OP_SET_RD : OP_SET_WR;
            end else if (i_reg_offset[12:2] == ISR_BASE[12:2] && i_kind == KIND_READ) begin
                n_cmd.op = OP_ISR_RD;
            end
        end
    end

    assign o_busy  = r_valid && !i_pop;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_start && !o_busy) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ design/dsdma_back.sv @@
// ----------------------------------------------------------------------------
// dsdma_back
// Holds the channel state, carries out one operation and registers the result.
// ----------------------------------------------------------------------------
module dsdma_back
    import dsdma_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_moved_count,
    output logic [31:0] o_mem_address,
    output logic        o_bus_error_now,
    output logic        o_set_complete,
    output logic        o_dma_irq,
    output logic [6:0]  o_ready_mask
);

    localparam int SETS = 2 * CHANNELS;
    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW   = $clog2(SETS);

    logic [31:0] r_addr [SETS];
    logic [31:0] r_cnt  [SETS];
    logic [4:0]  r_cs   [SETS];
    logic [CHANNELS-1:0] r_act, r_pau, r_cie, r_berr, r_sense;
    logic [31:0] n_addr [SETS];
    logic [31:0] n_cnt  [SETS];
    logic [4:0]  n_cs   [SETS];
    logic [CHANNELS-1:0] n_act, n_pau, n_cie, n_berr, n_sense;

    t_state r_state, n_state;
    logic        r_done;
    logic [7:0]  r_rd;
    logic [15:0] r_moved;
    logic [31:0] r_maddr;
    logic        r_be, r_sc;
    logic [7:0]  n_rd;
    logic [15:0] n_moved;
    logic [31:0] n_maddr;
    logic        n_be, n_sc;

    logic [CW-1:0] ch;
    logic [SW-1:0] si, sa, sb, sx;
    logic [31:0]   isr;
    logic [CHANNELS-1:0] pend, rdy;
    logic [1:0]    lane;
    logic [31:0]   take;
    logic [31:0]   left;
    logic          sense;

    assign ch    = i_cmd.chan[CW-1:0];
    assign sa    = SW'({ch, 1'b0});
    assign sb    = SW'({ch, 1'b1});
    assign si    = SW'({ch, i_cmd.set_sel});
    assign sx    = SW'({ch, r_act[ch]});
    assign lane  = i_cmd.sub[1:0];
    assign sense = i_cmd.wdata[7];
    assign take  = (32'(i_cmd.length) < r_cnt[sx]) ? 32'(i_cmd.length) : r_cnt[sx];
    assign left  = r_cnt[sx] - take;

    always_comb begin
        isr = '0;
        for (int n = 0; n < CHANNELS; n++) begin
            pend[n] = ((r_cs[2*n] & CS_IF) != 0 && (r_cs[2*n] & CS_IE) != 0) ||
                      ((r_cs[2*n+1] & CS_IF) != 0 && (r_cs[2*n+1] & CS_IE) != 0);
            isr[31-n] = pend[n] && r_cie[n];
        end
    end

    always_comb begin
        o_ready_mask = '0;
        for (int n = 0; n < CHANNELS; n++) begin
            rdy[n] = !r_pau[n] && (r_cs[2*n + int'(r_act[n])] & CS_EN) != 0 &&
                     r_cnt[2*n + int'(r_act[n])] != 0;
            if (n < 7) begin
                o_ready_mask[n] = rdy[n];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = i_valid ? ST_EXEC : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_addr = r_addr; n_cnt = r_cnt; n_cs = r_cs;
        n_act = r_act; n_pau = r_pau; n_cie = r_cie; n_berr = r_berr; n_sense = r_sense;
        n_rd = '0; n_moved = '0; n_maddr = '0; n_be = 1'b0; n_sc = 1'b0;
        if (i_valid) begin
            case (i_cmd.op)
                OP_CTRL_RD: begin
                    if (i_cmd.sub == 4'd0) begin
                        n_rd = {r_sense[ch], 1'b0, r_berr[ch], r_cie[ch], 1'b0,
                                r_pau[ch], 1'b0, ((r_cs[sa] | r_cs[sb]) & CS_IF) != 0};
                        n_rd[6] = r_pau[ch];
                    end else if (i_cmd.sub == 4'd1) begin
                        n_rd = {7'd0, r_act[ch]};
                    end
                end
                OP_SET_RD: begin
                    if (i_cmd.sub < 4'd4) begin
                        n_rd = 8'(r_addr[si] >> (5'd8 * (5'd3 - 5'(lane))));
                    end else if (i_cmd.sub < 4'd8) begin
                        n_rd = 8'(r_cnt[si] >> (5'd8 * (5'd3 - 5'(lane))));
                    end else if (i_cmd.sub == 4'd8) begin
                        n_rd = {3'd0, r_cs[si]};
                    end
                end
                OP_ISR_RD: n_rd = 8'(isr >> (5'd8 * (5'd3 - 5'(lane))));
                OP_CTRL_WR: begin
                    if (i_cmd.sub == 4'd0) begin
                        n_sense[ch] = sense;
                        if (i_cmd.wdata[2]) n_pau[ch] = sense;
                        if (i_cmd.wdata[3] && sense) begin
                            n_pau[ch] = 1'b1;
                            n_cs[sa] = r_cs[sa] & ~CS_EN;
                            n_cs[sb] = r_cs[sb] & ~CS_EN;
                        end
                        if (i_cmd.wdata[4]) n_cie[ch] = sense;
                        if (i_cmd.wdata[5] && !sense) n_berr[ch] = 1'b0;
                    end
                end
                OP_SET_WR: begin
                    if (i_cmd.sub < 4'd4) begin
                        for (int b = 0; b < 4; b++)
                            if (3 - b == int'(lane)) n_addr[si][8*b +: 8] = i_cmd.wdata;
                    end else if (i_cmd.sub < 4'd8) begin
                        for (int b = 0; b < 4; b++)
                            if (3 - b == int'(lane)) n_cnt[si][8*b +: 8] = i_cmd.wdata;
                    end else if (i_cmd.sub == 4'd8) begin
                        n_cs[si] = sense ? (r_cs[si] | i_cmd.wdata[4:0])
                                         : (r_cs[si] & ~i_cmd.wdata[4:0]);
                    end
                end
                OP_XFER: begin
                    if (!r_pau[ch] && (r_cs[sx] & CS_EN) != 0 &&
                        (((r_cs[sx] & CS_DIR) != 0) == i_cmd.to_mem) && r_cnt[sx] != 0) begin
                        if (r_addr[sx] >= ADDR_LIMIT) begin
                            n_berr[ch] = 1'b1;
                            n_be = 1'b1;
                        end else begin
                            n_maddr = r_addr[sx];
                            n_moved = take[15:0];
                            n_addr[sx] = r_addr[sx] + take;
                            n_cnt[sx] = left;
                            if (left == 0) begin
                                n_cs[sx] = (r_cs[sx] & ~CS_EN) | CS_TERM | CS_IF;
                                n_act[ch] = ~r_act[ch];
                                n_sc = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_pop = i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_act <= '0; r_pau <= '0; r_cie <= '0; r_berr <= '0; r_sense <= '0;
            for (int k = 0; k < SETS; k++) begin
                r_addr[k] <= '0; r_cnt[k] <= '0; r_cs[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= i_valid;
            r_act <= n_act; r_pau <= n_pau; r_cie <= n_cie; r_berr <= n_berr;
            r_sense <= n_sense;
            r_addr <= n_addr; r_cnt <= n_cnt; r_cs <= n_cs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_moved <= '0; r_maddr <= '0; r_be <= 1'b0; r_sc <= 1'b0;
        end else begin
            r_rd <= n_rd; r_moved <= n_moved; r_maddr <= n_maddr; r_be <= n_be;
            r_sc <= n_sc;
        end
    end

    assign o_done          = r_done && (r_state == ST_EXEC);
    assign o_read_data     = r_rd;
    assign o_moved_count   = r_moved;
    assign o_mem_address   = r_maddr;
    assign o_bus_error_now = r_be;
    assign o_set_complete  = r_sc;
    assign o_dma_irq       = isr != 0;

endmodule

@@ design/dual_set_dma_channel_engine_unit.sv @@
// ----------------------------------------------------------------------------
// dual_set_dma_channel_engine_unit
// Dual-set DMA channel engine: register access and transfer grants.
//
// Channel   Handshake          Payload
// command   start / busy       kind, reg_offset, write_data, channel, dev_to_mem, length
// result    o_done strobe      read_data, moved_count, mem_address, flags, ready_mask
//
// A command is queued in the front stage and carried out by the back stage
// in the following cycle; its result strobes in the cycle after that.
// One command per cycle is sustained: the single queue entry drains every cycle.
// Reset is synchronous and clears all channel state at once.
// The result cannot be stalled.
// ----------------------------------------------------------------------------
module dual_set_dma_channel_engine_unit
    import dsdma_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [12:0] i_reg_offset,
    input  logic [7:0]  i_write_data,
    input  logic [2:0]  i_channel,
    input  logic        i_dev_to_mem,
    input  logic [15:0] i_length,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_moved_count,
    output logic [31:0] o_mem_address,
    output logic        o_bus_error_now,
    output logic        o_set_complete,
    output logic        o_dma_irq,
    output logic [6:0]  o_ready_mask
);

    logic q_valid, q_pop;
    t_cmd q_cmd;

    dsdma_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_kind, .i_reg_offset, .i_write_data,
        .i_channel, .i_dev_to_mem, .i_length, .i_pop(q_pop), .o_busy(busy),
        .o_valid(q_valid), .o_cmd(q_cmd)
    );

    dsdma_back #(.CHANNELS(CHANNELS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_cmd(q_cmd), .o_pop(q_pop), .o_done,
        .o_read_data, .o_moved_count, .o_mem_address, .o_bus_error_now,
        .o_set_complete, .o_dma_irq, .o_ready_mask
    );

endmodule

@@ design/dsdma_checker.sv @@
// ----------------------------------------------------------------------------
// dsdma_checker
// Port-level checks of the DMA channel engine.
// ----------------------------------------------------------------------------
`include "dual_set_dma_channel_engine_unit_assert.svh"
module dsdma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [15:0] o_moved_count,
    input logic        o_bus_error_now,
    input logic        o_set_complete
);

    `DSD_ASSERT_NEXT(a_busy_never, i_clk, i_rst_n, 1'b1, !busy, "engine reported busy")
    `DSD_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, start && !busy, ##1 o_done,
        "transaction gave no result")
    `DSD_ASSERT_IMPL(a_berr_excl, i_clk, i_rst_n, o_bus_error_now,
        o_moved_count == 16'd0 && !o_set_complete, "bus error with a move")
    `DSD_ASSERT_IMPL(a_no_spurious, i_clk, i_rst_n, !o_done,
        !o_bus_error_now && !o_set_complete, "flags outside a result")

endmodule

bind dual_set_dma_channel_engine_unit dsdma_checker u_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_moved_count,
    .o_bus_error_now, .o_set_complete
);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the dual-set DMA channel engine. A local model
// of the channel register sets predicts every result; a monitor compares each
// strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dsdma_pkg::*;

    localparam int          NCH       = 7;
    localparam logic [1:0]  KIND_NOP  = 2'd3;
    localparam logic [7:0]  SENSE     = 8'h80;
    localparam logic [7:0]  CTL_PAUSE = 8'h04;
    localparam logic [7:0]  CTL_RESET = 8'h08;
    localparam logic [7:0]  CTL_IRQEN = 8'h10;
    localparam logic [7:0]  CTL_BERR  = 8'h20;
    localparam int          STALL_MAX = 1000;

    typedef struct {
        logic [7:0]  rd;
        logic [15:0] moved;
        logic [31:0] maddr;
        logic        berr;
        logic        done;
        logic        irq;
        logic [6:0]  ready;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_kind = '0;
    logic [12:0] i_reg_offset = '0;
    logic [7:0]  i_write_data = '0;
    logic [2:0]  i_channel = '0;
    logic        i_dev_to_mem = 1'b0;
    logic [15:0] i_length = '0;
    logic        o_done;
    logic [7:0]  o_read_data;
    logic [15:0] o_moved_count;
    logic [31:0] o_mem_address;
    logic        o_bus_error_now;
    logic        o_set_complete;
    logic        o_dma_irq;
    logic [6:0]  o_ready_mask;

    logic [31:0] set_addr [2*NCH];
    logic [31:0] set_cnt  [2*NCH];
    logic [4:0]  set_cs   [2*NCH];
    logic        act      [NCH];
    logic        paused   [NCH];
    logic        irq_en   [NCH];
    logic        berr_lat [NCH];
    logic        sense_ec [NCH];

    t_result pending_results[$];
    int      error_count = 0;
    int      stall_count = 0;
    bit      idling_on = 1'b1;
    int      sent_items = 0;

    dual_set_dma_channel_engine_unit dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic logic [31:0] irq_status();
        logic [31:0] w;
        w = '0;
        for (int n = 0; n < NCH; n++) begin
            if (irq_en[n] && (((set_cs[2*n] & CS_IF) != 0 && (set_cs[2*n] & CS_IE) != 0) ||
                              ((set_cs[2*n+1] & CS_IF) != 0 && (set_cs[2*n+1] & CS_IE) != 0)))
                w[31-n] = 1'b1;
        end
        return w;
    endfunction

    function automatic logic [6:0] ready_bits();
        logic [6:0] m;
        int i;
        m = '0;
        for (int n = 0; n < NCH; n++) begin
            i = 2*n + act[n];
            if (!paused[n] && (set_cs[i] & CS_EN) != 0 && set_cnt[i] != 0) m[n] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [7:0] lane_of(logic [31:0] v, int lane);
        return 8'(v >> (8 * (3 - (lane & 3))));
    endfunction

    function automatic logic [7:0] read_byte(int off);
        int n, i, r;
        logic [7:0] v;
        v = '0;
        if (off >= CTRL_BASE && off < CTRL_BASE + 16*NCH) begin
            n = (off - CTRL_BASE) >> 4;
            r = off & 15;
            if (r == 0) begin
                if (((set_cs[2*n] | set_cs[2*n+1]) & CS_IF) != 0) v |= 8'h01;
                if (paused[n]) v |= 8'h44;
                if (irq_en[n]) v |= 8'h10;
                if (berr_lat[n]) v |= 8'h20;
                if (sense_ec[n]) v |= 8'h80;
            end else if (r == 1) begin
                v = {7'd0, act[n]};
            end
        end else if (off >= SET_BASE && off < SET_BASE + 32*NCH) begin
            n = (off - SET_BASE) >> 5;
            i = 2*n + ((off >> 4) & 1);
            r = off & 15;
            if (r < 4) v = lane_of(set_addr[i], r);
            else if (r < 8) v = lane_of(set_cnt[i], r);
            else if (r == 8) v = {3'd0, set_cs[i]};
        end else if ((off & ~3) == ISR_BASE) begin
            v = lane_of(irq_status(), off);
        end
        return v;
    endfunction

    task automatic write_byte(int off, logic [7:0] v);
        int n, i, r, sh;
        logic s;
        s = v[7];
        if (off >= CTRL_BASE && off < CTRL_BASE + 16*NCH) begin
            n = (off - CTRL_BASE) >> 4;
            if ((off & 15) == 0) begin
                sense_ec[n] = s;
                if ((v & CTL_PAUSE) != 0) paused[n] = s;
                if ((v & CTL_RESET) != 0 && s) begin
                    paused[n] = 1'b1;
                    set_cs[2*n] &= ~CS_EN;
                    set_cs[2*n+1] &= ~CS_EN;
                end
                if ((v & CTL_IRQEN) != 0) irq_en[n] = s;
                if ((v & CTL_BERR) != 0 && !s) berr_lat[n] = 1'b0;
            end
        end else if (off >= SET_BASE && off < SET_BASE + 32*NCH) begin
            n = (off - SET_BASE) >> 5;
            i = 2*n + ((off >> 4) & 1);
            r = off & 15;
            sh = 8 * (3 - (r & 3));
            if (r < 4) set_addr[i] = (set_addr[i] & ~(32'hFF << sh)) | (32'(v) << sh);
            else if (r < 8) set_cnt[i] = (set_cnt[i] & ~(32'hFF << sh)) | (32'(v) << sh);
            else if (r == 8) begin
                if (s) set_cs[i] |= v[4:0];
                else set_cs[i] &= ~v[4:0];
            end
        end
    endtask

    task automatic predict_result(logic [1:0] k, logic [12:0] off, logic [7:0] wd,
                                  logic [2:0] ch, logic tm, logic [15:0] len);
        t_result e;
        int i;
        logic [31:0] cnt;
        e = '{default: '0};
        if (k == KIND_READ) begin
            e.rd = read_byte(off);
        end else if (k == KIND_WRITE) begin
            write_byte(off, wd);
        end else if (k == KIND_XFER && ch < NCH) begin
            i = 2*ch + act[ch];
            if (!paused[ch] && (set_cs[i] & CS_EN) != 0 &&
                    (((set_cs[i] & CS_DIR) != 0) == tm) && set_cnt[i] != 0) begin
                if (set_addr[i] >= ADDR_LIMIT) begin
                    berr_lat[ch] = 1'b1;
                    e.berr = 1'b1;
                end else begin
                    cnt = (32'(len) < set_cnt[i]) ? 32'(len) : set_cnt[i];
                    e.maddr = set_addr[i];
                    e.moved = cnt[15:0];
                    set_addr[i] += cnt;
                    set_cnt[i] -= cnt;
                    if (set_cnt[i] == 0) begin
                        set_cs[i] = (set_cs[i] & ~CS_EN) | CS_TERM | CS_IF;
                        act[ch] = ~act[ch];
                        e.done = 1'b1;
                    end
                end
            end
        end
        e.irq = irq_status() != 0;
        e.ready = ready_bits();
        pending_results.push_back(e);
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                e = pending_results.pop_front();
                if (o_read_data !== e.rd) report_mismatch("read_data", o_read_data, e.rd);
                if (o_moved_count !== e.moved)
                    report_mismatch("moved_count", o_moved_count, e.moved);
                if (o_mem_address !== e.maddr)
                    report_mismatch("mem_address", o_mem_address, e.maddr);
                if (o_bus_error_now !== e.berr)
                    report_mismatch("bus_error_now", o_bus_error_now, e.berr);
                if (o_set_complete !== e.done)
                    report_mismatch("set_complete", o_set_complete, e.done);
                if (o_dma_irq !== e.irq) report_mismatch("dma_irq", o_dma_irq, e.irq);
                if (o_ready_mask !== e.ready)
                    report_mismatch("ready_mask", o_ready_mask, e.ready);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_count = 0;
        else stall_count++;
        if (stall_count >= STALL_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] k, logic [12:0] off, logic [7:0] wd,
                             logic [2:0] ch, logic tm, logic [15:0] len);
        @(negedge i_clk);
        start <= 1'b1;
        i_kind <= k;
        i_reg_offset <= off;
        i_write_data <= wd;
        i_channel <= ch;
        i_dev_to_mem <= tm;
        i_length <= len;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_result(k, off, wd, ch, tm, len);
        sent_items++;
        if (idling_on && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [12:0] set_off(int ch, int s, int r);
        return 13'(SET_BASE + 32*ch + 16*s + r);
    endfunction

    function automatic logic [12:0] ctl_off(int ch);
        return 13'(CTRL_BASE + 16*ch);
    endfunction

    task automatic program_set(int ch, int s, logic [31:0] addr, logic [31:0] cnt,
                               logic [4:0] bits);
        for (int r = 0; r < 4; r++) send_item(KIND_WRITE, set_off(ch, s, r), lane_of(addr, r),
                                             0, 0, 0);
        for (int r = 0; r < 4; r++) send_item(KIND_WRITE, set_off(ch, s, 4 + r),
                                             lane_of(cnt, r), 0, 0, 0);
        send_item(KIND_WRITE, set_off(ch, s, 8), 8'h1F, 0, 0, 0);
        send_item(KIND_WRITE, set_off(ch, s, 8), SENSE | bits, 0, 0, 0);
    endtask

    task automatic test_register_map();
        send_item(KIND_READ, ctl_off(0), 0, 0, 0, 0);
        send_item(KIND_READ, ISR_BASE, 0, 0, 0, 0);
        send_item(KIND_WRITE, ctl_off(6), SENSE | CTL_PAUSE | CTL_IRQEN, 0, 0, 0);
        send_item(KIND_READ, ctl_off(6), 0, 0, 0, 0);
        send_item(KIND_WRITE, ctl_off(6) + 13'd2, 8'hFF, 0, 0, 0);
        send_item(KIND_WRITE, ISR_BASE + 13'd3, 8'hFF, 0, 0, 0);
        send_item(KIND_WRITE, 13'h1FFF, 8'hFF, 0, 0, 0);
        send_item(KIND_READ, 13'h1FFF, 0, 0, 0, 0);
        send_item(KIND_READ, ctl_off(7), 0, 0, 0, 0);
        send_item(KIND_NOP, 13'h1FFF, 8'hFF, 3'd7, 1, 16'hFFFF);
        send_item(KIND_WRITE, ctl_off(6), CTL_PAUSE | CTL_IRQEN | CTL_BERR, 0, 0, 0);
    endtask

    task automatic test_transfer_cases();
        program_set(0, 0, 32'h3FFF_FFF0, 32'd16, CS_EN | CS_DIR | CS_IE);
        send_item(KIND_WRITE, ctl_off(0), SENSE | CTL_IRQEN, 0, 0, 0);
        send_item(KIND_XFER, 0, 0, 3'd0, 0, 16'd4);
        send_item(KIND_XFER, 0, 0, 3'd0, 1, 16'd0);
        send_item(KIND_XFER, 0, 0, 3'd0, 1, 16'hFFFF);
        send_item(KIND_XFER, 0, 0, 3'd7, 1, 16'd1);
        send_item(KIND_READ, ISR_BASE, 0, 0, 0, 0);
        send_item(KIND_READ, ctl_off(0) + 13'd1, 0, 0, 0, 0);
        program_set(0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CS_EN);
        send_item(KIND_XFER, 0, 0, 3'd0, 0, 16'd1);
        send_item(KIND_READ, ctl_off(0), 0, 0, 0, 0);
        send_item(KIND_WRITE, ctl_off(0), SENSE | CTL_RESET, 0, 0, 0);
        send_item(KIND_XFER, 0, 0, 3'd0, 0, 16'd1);
        drain_results();
    endtask

    task automatic test_random_sequences(int target);
        int ch, s, k;
        logic [31:0] addr;
        logic [31:0] cnt;
        logic [4:0] bits;
        while (sent_items < target) begin
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(0, 3);
                send_item(2'(k), 13'($urandom()), 8'($urandom()), 3'($urandom()),
                          1'($urandom()), 16'($urandom()));
                continue;
            end
            ch = $urandom_range(0, NCH - 1);
            s = ($urandom_range(0, 4) == 0) ? ~act[ch] : act[ch];
            addr = ($urandom_range(0, 9) == 0) ? $urandom() : {2'b00, 30'($urandom())};
            cnt = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 300);
            bits = CS_EN | ($urandom_range(0, 1) ? CS_DIR : 5'h0) |
                   ($urandom_range(0, 1) ? CS_IE : 5'h0);
            program_set(ch, s, addr, cnt, bits);
            send_item(KIND_WRITE, ctl_off(ch), CTL_PAUSE | CTL_BERR |
                      ($urandom_range(0, 1) ? (SENSE | CTL_IRQEN) : 8'h0), 0, 0, 0);
            repeat ($urandom_range(2, 8)) begin
                send_item(KIND_XFER, 0, 8'($urandom()), 3'(ch),
                          ($urandom_range(0, 7) == 0) ? ~bits[1] : bits[1],
                          ($urandom_range(0, 15) == 0) ? 16'($urandom()) :
                          16'($urandom_range(0, 120)));
            end
            send_item(KIND_READ, 13'(ctl_off(ch) + $urandom_range(0, 1)), 0, 0, 0, 0);
            send_item(KIND_READ, 13'(ISR_BASE + $urandom_range(0, 3)), 0, 0, 0, 0);
            send_item(KIND_READ, set_off(ch, $urandom_range(0, 1), $urandom_range(0, 9)),
                      0, 0, 0, 0);
        end
    endtask

    initial begin
        for (int i = 0; i < 2*NCH; i++) begin
            set_addr[i] = '0;
            set_cnt[i] = '0;
            set_cs[i] = '0;
        end
        for (int n = 0; n < NCH; n++) begin
            act[n] = 0;
            paused[n] = 0;
            irq_en[n] = 0;
            berr_lat[n] = 0;
            sense_ec[n] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_map();
        test_transfer_cases();
        test_random_sequences(1150);
        drain_results();
        idling_on = 1'b0;
        test_random_sequences(1450);
        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

@@ dual_set_dma_channel_engine_unit.f @@
+incdir+design
design/dsdma_pkg.sv
design/dsdma_front.sv
design/dsdma_back.sv
design/dual_set_dma_channel_engine_unit.sv
design/dsdma_checker.sv
verif/tb_top.sv
